// ===== sv/mlfq_pkg.sv =====
// ----------------------------------------------------------------------------
// mlfq_pkg
// Shared types and constants of the multilevel feedback queue scheduler.
// ----------------------------------------------------------------------------
package mlfq_pkg;

  localparam int unsigned LEVELS_DEF      = 4;
  localparam int unsigned MAX_THREADS_DEF = 16;
  // Level field width covers the largest supported level count (8).
  localparam int unsigned LVL_W           = 3;
  localparam int unsigned TID_W           = 4;
  localparam logic [15:0] BOOST_PERIOD_RST = 16'd1000;

  typedef enum logic [2:0] {
    OP_CREATE  = 3'd0,
    OP_PREEMPT = 3'd1,
    OP_YIELD   = 3'd2,
    OP_EXIT    = 3'd3,
    OP_TICK    = 3'd4
  } opcode_e;

  typedef struct packed {
    logic [2:0] opcode;
    logic [3:0] slot_id;
  } in_item_t;

  typedef struct packed {
    logic       running_valid;
    logic [3:0] run_slot;
    logic [1:0] running_level;
    logic       status;
  } out_item_t;

  // One queued thread as held by a cell.
  typedef struct packed {
    logic             valid;
    logic [TID_W-1:0] tid;
    logic [LVL_W-1:0] lvl;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_SHIFT  = 2'd1,
    CELL_INSERT = 2'd2,
    CELL_BOOST  = 2'd3
  } cell_op_e;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    cell_op_e op;
    entry_t   key;
  } cell_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_EXEC  = 3'd1,
    ST_INS   = 3'd2,
    ST_BOOST = 3'd3,
    ST_DONE  = 3'd4
  } state_e;

endpackage

// ===== sv/mlfq_cell.sv =====
// ----------------------------------------------------------------------------
// mlfq_cell
// One position of the sorted thread row: shifts, takes an insert, or boosts.
// ----------------------------------------------------------------------------
module mlfq_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mlfq_pkg::cell_cmd_t cmd_i,
  input  mlfq_pkg::entry_t   left_i,
  input  mlfq_pkg::entry_t   right_i,
  output mlfq_pkg::entry_t   entry_o
);

  mlfq_pkg::entry_t entry_q, entry_d;
  logic self_before, left_before;

  // An entry stays ahead of a new key when its level is not lower in priority.
  assign self_before = entry_q.valid && (entry_q.lvl <= cmd_i.key.lvl);
  assign left_before = left_i.valid && (left_i.lvl <= cmd_i.key.lvl);

  always_comb begin
    entry_d = entry_q;
    unique case (cmd_i.op)
      mlfq_pkg::CELL_HOLD:  entry_d = entry_q;
      mlfq_pkg::CELL_SHIFT: entry_d = right_i;
      mlfq_pkg::CELL_INSERT: begin
        if (self_before) begin
          entry_d = entry_q;
        end else if (left_before) begin
          entry_d = cmd_i.key;
        end else begin
          entry_d = left_i;
        end
      end
      mlfq_pkg::CELL_BOOST: entry_d.lvl = '0;
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

// ===== sv/mlfq_thread_scheduler.sv =====
// ----------------------------------------------------------------------------
// mlfq_thread_scheduler
// Multilevel feedback queue scheduler built as a sorted row of thread cells.
// ----------------------------------------------------------------------------
// All queued threads sit in one row of MAX_THREADS cells, kept sorted by
// level and, within a level, by queue order, so the running thread is always
// the first cell. Every event is one input transfer and produces exactly one
// result transfer. Each event passes ST_EXEC and then ST_DONE, where the result
// register is loaded. A preempt or yield that moves the head leaves the row in
// ST_EXEC and is re-inserted at its tail position in ST_INS, and an exit with
// a due boost clears the levels in ST_BOOST; both states lie between ST_EXEC
// and ST_DONE. A preempt or yield that boosts does so in ST_EXEC. In each row
// operation every cell either keeps its entry, takes its right neighbor
// (removal of the head), takes its left neighbor or the new key (sorted
// insert), or clears its level (boost). A boost keeps the row order, which
// is exactly the level-then-queue order, so it is a single row operation.
// The next input is taken in the cycle after the result has been loaded into
// the output register; the result then waits there while the next event is
// processed, and a result still waiting when the next one is ready stalls the
// block. The boost_period register may be written at any time through its
// own port.
// ----------------------------------------------------------------------------
module mlfq_thread_scheduler #(
  parameter int unsigned LEVELS      = mlfq_pkg::LEVELS_DEF,
  parameter int unsigned MAX_THREADS = mlfq_pkg::MAX_THREADS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mlfq_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mlfq_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [15:0]         cfg_data_i
);

  localparam logic [mlfq_pkg::LVL_W-1:0] LastLvl = mlfq_pkg::LVL_W'(LEVELS - 1);

  mlfq_pkg::state_e    state_q, state_d;
  mlfq_pkg::cell_cmd_t cmd;
  mlfq_pkg::entry_t    cells [MAX_THREADS];
  mlfq_pkg::entry_t    key_q, key_d;
  mlfq_pkg::entry_t    head, head_sentinel, tail_empty;
  mlfq_pkg::out_item_t out_q, out_d;

  logic [2:0]  op_q;
  logic [3:0]  tid_q;
  logic        boost_due_q;
  logic        status_q, status_d;
  logic        out_valid_q, out_valid_d;
  logic [15:0] period_q;
  logic [15:0] count_q, count_d;
  logic        in_fire, full;

  // The left neighbor of the first cell always counts as ahead of any key,
  // and the right neighbor of the last cell is empty.
  assign head_sentinel = '{valid: 1'b1, tid: '0, lvl: '0};
  assign tail_empty    = '0;

  for (genvar g = 0; g < MAX_THREADS; g++) begin : g_row
    mlfq_cell u_cell (
      .clk_i,
      .rst_ni,
      .cmd_i   (cmd),
      .left_i  ((g == 0) ? head_sentinel : cells[(g == 0) ? 0 : g - 1]),
      .right_i ((g == MAX_THREADS - 1) ? tail_empty
                : cells[(g == MAX_THREADS - 1) ? g : g + 1]),
      .entry_o (cells[g])
    );
  end

  assign head = cells[0];
  assign full = cells[MAX_THREADS-1].valid;

  assign in_ready_o  = (state_q == mlfq_pkg::ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // Boost period register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= mlfq_pkg::BOOST_PERIOD_RST;
    end else if (cfg_valid_i) begin
      period_q <= cfg_data_i;
    end
  end

  // Latched event; the boost decision is taken from the counter as it stood
  // when the event arrived.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q        <= in_data_i.opcode;
      tid_q       <= in_data_i.slot_id;
      boost_due_q <= (count_q >= period_q);
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd.op      = mlfq_pkg::CELL_HOLD;
    cmd.key     = key_q;
    key_d       = key_q;
    status_d    = status_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    unique case (state_q)
      mlfq_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d  = mlfq_pkg::ST_EXEC;
          status_d = 1'b0;
        end
      end
      mlfq_pkg::ST_EXEC: begin
        state_d = mlfq_pkg::ST_DONE;
        unique case (op_q)
          mlfq_pkg::OP_CREATE: begin
            if (full) begin
              status_d = 1'b1;
            end else begin
              cmd.op  = mlfq_pkg::CELL_INSERT;
              cmd.key = '{valid: 1'b1, tid: tid_q, lvl: '0};
            end
          end
          mlfq_pkg::OP_EXIT: begin
            if (head.valid) begin
              cmd.op = mlfq_pkg::CELL_SHIFT;
            end
            if (boost_due_q) begin
              state_d = mlfq_pkg::ST_BOOST;
            end
          end
          mlfq_pkg::OP_PREEMPT, mlfq_pkg::OP_YIELD: begin
            if (boost_due_q) begin
              cmd.op  = mlfq_pkg::CELL_BOOST;
              count_d = '0;
            end else if (head.valid) begin
              cmd.op = mlfq_pkg::CELL_SHIFT;
              key_d  = head;
              if (op_q == mlfq_pkg::OP_PREEMPT && head.lvl < LastLvl) begin
                key_d.lvl = head.lvl + 1'b1;
              end
              state_d = mlfq_pkg::ST_INS;
            end
          end
          mlfq_pkg::OP_TICK: begin
            if (count_q != 16'hFFFF) begin
              count_d = count_q + 16'd1;
            end
          end
          default: ;
        endcase
      end
      mlfq_pkg::ST_INS: begin
        cmd.op  = mlfq_pkg::CELL_INSERT;
        state_d = mlfq_pkg::ST_DONE;
      end
      mlfq_pkg::ST_BOOST: begin
        cmd.op  = mlfq_pkg::CELL_BOOST;
        count_d = '0;
        state_d = mlfq_pkg::ST_DONE;
      end
      mlfq_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d          = 1'b1;
          out_d.running_valid  = head.valid;
          out_d.run_slot       = head.valid ? head.tid : '0;
          out_d.running_level  = head.valid ? head.lvl[1:0] : '0;
          out_d.status         = status_q;
          state_d              = mlfq_pkg::ST_IDLE;
        end
      end
      default: state_d = mlfq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mlfq_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      status_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== sv/mlfq_checker.sv =====
// ----------------------------------------------------------------------------
// mlfq_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module mlfq_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input mlfq_pkg::out_item_t out_data_o
);

  // A waiting result is held until its transfer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  // One event is processed at a time.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an event is in progress");

  // With nothing queued the thread and level fields read zero.
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.running_valid |->
      out_data_o.run_slot == 4'd0 && out_data_o.running_level == 2'd0)
    else $error("nonzero thread fields with no running thread");

  // A refused create means the queues are full, so someone runs.
  a_full_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status |-> out_data_o.running_valid)
    else $error("create refused while queues empty");

endmodule

bind mlfq_thread_scheduler mlfq_checker u_mlfq_checker (
  .clk_i,
  .rst_ni,
  .in_valid_i,
  .in_ready_o,
  .out_valid_o,
  .out_ready_i,
  .out_data_o
);

// ===== tb/tb_mlfq_thread_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mlfq_thread_scheduler
// Self-checking bench for the multilevel feedback queue scheduler.
// ----------------------------------------------------------------------------
// A local model of the level queues predicts the running thread, its level
// and the status for every accepted event. The results are queued in order
// and compared field by field as the block hands them out. Directed events
// cover the special cases first, then mostly well-formed random traffic runs
// under several boost periods, with random idling on both sides and one long
// hold-off on the result side.
// ----------------------------------------------------------------------------
module tb_mlfq_thread_scheduler;

  localparam int NLVL = 4;
  localparam int NTHR = 16;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  mlfq_pkg::in_item_t  in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  mlfq_pkg::out_item_t out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [15:0]         cfg_data_i = '0;

  mlfq_thread_scheduler u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor state: each level is a plain queue of slot numbers.
  logic [3:0]          lvl_q[NLVL][$];
  int                  thread_cnt;
  logic [15:0]         tick_cnt;
  logic [15:0]         period;
  mlfq_pkg::out_item_t sched_expected[$];

  int  errors;
  bit  rx_idle_en;   // random idling allowed
  bit  hold_rx;      // long hold-off of the result side
  int  rx_gap = 0;   // remaining cycles of the current result-side idle burst

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  function automatic mlfq_pkg::out_item_t sched_predict(input mlfq_pkg::in_item_t ev);
    mlfq_pkg::out_item_t r;
    int          top;
    bit          boost;
    logic [3:0]  t;
    logic [3:0]  all[$];
    int          dst;
    r   = '0;
    top = NLVL;
    for (int l = NLVL - 1; l >= 0; l--) if (lvl_q[l].size() != 0) top = l;
    case (ev.opcode)
      mlfq_pkg::OP_CREATE: begin
        if (thread_cnt >= NTHR) r.status = 1'b1;
        else begin
          lvl_q[0].push_back(ev.slot_id);
          thread_cnt++;
        end
      end
      mlfq_pkg::OP_PREEMPT, mlfq_pkg::OP_YIELD, mlfq_pkg::OP_EXIT: begin
        boost = tick_cnt >= period;
        if (ev.opcode == mlfq_pkg::OP_EXIT && top < NLVL) begin
          void'(lvl_q[top].pop_front());
          thread_cnt--;
        end
        if (boost) begin
          // Concatenate all levels into the top level in level order.
          all = {};
          for (int l = 0; l < NLVL; l++) begin
            all = {all, lvl_q[l]};
            lvl_q[l] = {};
          end
          lvl_q[0] = all;
          tick_cnt = '0;
        end else if (ev.opcode != mlfq_pkg::OP_EXIT && top < NLVL) begin
          dst = (ev.opcode == mlfq_pkg::OP_PREEMPT && top + 1 < NLVL) ? top + 1 : top;
          t = lvl_q[top].pop_front();
          lvl_q[dst].push_back(t);
        end
      end
      mlfq_pkg::OP_TICK: if (tick_cnt != 16'hFFFF) tick_cnt++;
      default: ;
    endcase
    for (int l = NLVL - 1; l >= 0; l--) begin
      if (lvl_q[l].size() != 0) begin
        r.running_valid = 1'b1;
        r.run_slot      = lvl_q[l][0];
        r.running_level = l[1:0];
      end
    end
    return r;
  endfunction

  // Offer one event, hold it until the transfer, then record the prediction.
  // Valid stays high into the next event unless an idle burst comes first.
  task automatic send_event(input logic [2:0] op, input logic [3:0] tid,
                            input bit gaps = 1'b1);
    if (gaps && rx_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{opcode: op, slot_id: tid};
    do @(posedge clk_i); while (!in_ready_o);
    sched_expected.push_back(sched_predict('{opcode: op, slot_id: tid}));
  endtask

  // Wait for all results, allow the block to settle, then write the period.
  task automatic write_period(input logic [15:0] value);
    in_valid_i <= 1'b0;
    while (sched_expected.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    period = value;
  endtask

  // Result side: random idle bursts, plus the long hold-off.
  always @(posedge clk_i) begin
    if (hold_rx) begin
      out_ready_i <= 1'b0;
    end else if (rx_gap != 0) begin
      out_ready_i <= 1'b0;
      rx_gap      <= rx_gap - 1;
    end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
      out_ready_i <= 1'b0;
      rx_gap      <= $urandom_range(0, 16);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    mlfq_pkg::out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (sched_expected.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = sched_expected.pop_front();
        if (out_data_o.running_valid !== want.running_valid)
          report_mismatch("running_valid", out_data_o.running_valid, want.running_valid);
        if (out_data_o.run_slot !== want.run_slot)
          report_mismatch("run_slot", out_data_o.run_slot, want.run_slot);
        if (out_data_o.running_level !== want.running_level)
          report_mismatch("running_level", out_data_o.running_level, want.running_level);
        if (out_data_o.status !== want.status)
          report_mismatch("status", out_data_o.status, want.status);
      end
    end
  end

  // Special cases: empty queues, full queue refusal, duplicates, demotion,
  // unknown codes and every opcode with extreme slot numbers.
  task automatic test_directed();
    send_event(mlfq_pkg::OP_PREEMPT, 4'd0);
    send_event(mlfq_pkg::OP_YIELD, 4'd0);
    send_event(mlfq_pkg::OP_EXIT, 4'd0);
    send_event(3'd5, 4'd15);
    send_event(3'd7, 4'd0);
    send_event(mlfq_pkg::OP_CREATE, 4'd15);
    send_event(mlfq_pkg::OP_CREATE, 4'd15);  // same slot queued twice
    send_event(mlfq_pkg::OP_CREATE, 4'd0);
    for (int i = 0; i < 4; i++) send_event(mlfq_pkg::OP_PREEMPT, 4'd0);  // each demotes the head thread
    send_event(mlfq_pkg::OP_YIELD, 4'd0);
    send_event(mlfq_pkg::OP_TICK, 4'd15);
    send_event(3'd6, 4'd9);
    for (int i = 0; i < 14; i++) send_event(mlfq_pkg::OP_CREATE, i[3:0]);  // hits full
    for (int i = 0; i < 3; i++) send_event(mlfq_pkg::OP_EXIT, 4'd0);
  endtask

  // Period 0 boosts on every preempt, yield and exit.
  task automatic test_boost_zero();
    write_period(16'd0);
    for (int i = 0; i < 40; i++)
      send_event(3'($urandom_range(0, 4)), 4'($urandom_range(0, 15)));
  endtask

  // Random traffic weighted toward creates and demotions so threads spread
  // over all levels; ticks drive boosts under a small period.
  task automatic test_random(input int n, input int tick_w);
    int p;
    logic [2:0] op;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(0, 99);
      if (p < 22) op = mlfq_pkg::OP_CREATE;
      else if (p < 45) op = mlfq_pkg::OP_PREEMPT;
      else if (p < 57) op = mlfq_pkg::OP_YIELD;
      else if (p < 70) op = mlfq_pkg::OP_EXIT;
      else if (p < 70 + tick_w) op = mlfq_pkg::OP_TICK;
      else if (p < 97) op = mlfq_pkg::OP_PREEMPT;
      else op = 3'($urandom_range(5, 7));
      send_event(op, 4'($urandom_range(0, 15)));
    end
  endtask

  // The result side stops while events keep coming, filling the block.
  task automatic test_backpressure();
    hold_rx = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        hold_rx = 1'b0;
      end
      for (int i = 0; i < 20; i++)
        send_event(3'($urandom_range(0, 4)), 4'($urandom_range(0, 15)), 1'b0);
    join
  endtask

  // Under the top period a few ticks never reach a boost.
  task automatic test_long_period();
    write_period(16'hFFFF);
    for (int i = 0; i < 6; i++)
      send_event(mlfq_pkg::OP_CREATE, 4'($urandom_range(0, 15)), 1'b0);
    for (int i = 0; i < 8; i++)
      send_event(mlfq_pkg::OP_TICK, 4'($urandom_range(0, 15)), 1'b0);
    send_event(mlfq_pkg::OP_PREEMPT, 4'd0);
    send_event(mlfq_pkg::OP_YIELD, 4'd0);
  endtask

  initial begin
    errors     = 0;
    rx_idle_en = 1'b1;
    hold_rx    = 1'b0;
    thread_cnt = 0;
    tick_cnt   = '0;
    period     = mlfq_pkg::BOOST_PERIOD_RST;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_boost_zero();
    write_period(16'd1);
    test_random(200, 20);
    test_backpressure();
    write_period(16'd7);
    test_random(250, 12);
    write_period(16'd1000);
    test_random(150, 5);
    rx_idle_en = 1'b0;  // last part runs without idling
    write_period(16'd3);
    test_random(150, 15);
    test_long_period();
    in_valid_i <= 1'b0;
    while (sched_expected.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
